FILE: sv/bolm_pkg.sv
// ----------------------------------------------------------------------------
// bolm_pkg
// types and constants shared by the box overlap label matcher
// ----------------------------------------------------------------------------
package bolm_pkg;

  localparam int unsigned FIELD_COORD_W = 12;
  localparam int unsigned RATE_W        = 16;
  localparam int unsigned IDX_OUT_W     = 6;
  localparam int unsigned CNT_OUT_W     = 7;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd52429;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [11:0] box_width;
    logic [11:0] box_height;
    logic [7:0]  label_class;
    logic [15:0] label_confidence;
    logic [23:0] label_color;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        matched;
    logic [5:0]  match_index;
    logic [7:0]  match_class;
    logic [15:0] match_confidence;
    logic [23:0] match_color;
    logic [15:0] overlap_rate;
    logic [6:0]  entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic add;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_empty;
    logic div_done;
    logic is_match;
  } sts_t;

endpackage

FILE: sv/box_overlap_label_matcher.sv
// ----------------------------------------------------------------------------
// box_overlap_label_matcher
// table of labelled reference boxes matched to query boxes by dice overlap
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in      | input     | in_valid_i, in_ready_o, in_item_i
//  out     | output    | out_valid_o, out_ready_i, out_item_o
//  cfg     | input     | cfg_valid_i, cfg_ready_o, cfg_data_i
//
//  clear, add and the unused code go straight to the result and wait for it to be taken
//  query walks the table through the scoring pipeline and waits for it to drain,
//  then on a match runs the one bit per cycle divider before the result is offered
//  one item at a time; the next item is taken after the result is taken
//  reset empties the table and loads the threshold default
module box_overlap_label_matcher #(
  parameter int unsigned MAX_REFERENCES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bolm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bolm_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import bolm_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [15:0] min_rate_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rate_q <= RATE_RESET;
    end else if (cfg_valid_i) begin
      min_rate_q <= cfg_data_i;
    end
  end

  bolm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (in_item_i.operation),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  bolm_dp #(
    .MAX_REFERENCES (MAX_REFERENCES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .min_rate_i (min_rate_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule

FILE: sv/bolm_ctrl.sv
// ----------------------------------------------------------------------------
// bolm_ctrl
// sequencer for clear, add and query items
// ----------------------------------------------------------------------------
module bolm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      op_i,
  input  logic            out_ready_i,
  input  bolm_pkg::sts_t  sts_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output bolm_pkg::cmd_t  cmd_o
);
  import bolm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (op_i)
            OP_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d = ST_OUT;
            end
            OP_ADD: begin
              cmd_o.add = 1'b1;
              state_d = ST_OUT;
            end
            OP_QUERY: begin
              cmd_o.scan_start = 1'b1;
              state_d = ST_SCAN;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) begin
          if (sts_i.is_match) begin
            cmd_o.div_start = 1'b1;
            state_d = ST_DIV;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/bolm_dp.sv
// ----------------------------------------------------------------------------
// bolm_dp
// reference table, overlap scoring pipeline and overlap divider
// ----------------------------------------------------------------------------
module bolm_dp #(
  parameter int unsigned MAX_REFERENCES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bolm_pkg::in_item_t  in_item_i,
  input  logic [15:0]         min_rate_i,
  input  bolm_pkg::cmd_t      cmd_i,
  output bolm_pkg::sts_t      sts_o,
  output bolm_pkg::out_item_t out_item_o
);
  import bolm_pkg::*;

  localparam int unsigned COORD_BITS = FIELD_COORD_W;
  localparam int unsigned AW = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam int unsigned CW = $clog2(MAX_REFERENCES + 1);
  localparam int unsigned EW = COORD_BITS + 1;
  localparam int unsigned IW = 2 * COORD_BITS;
  localparam int unsigned SW = 2 * COORD_BITS + 1;
  localparam int unsigned GW = 4 * COORD_BITS;
  localparam int unsigned LW = 48;
  localparam int unsigned NW = IW + 17;
  localparam int unsigned DCW = $clog2(NW + 1);

  logic [GW-1:0] geo_mem [MAX_REFERENCES];
  logic [LW-1:0] lab_mem [MAX_REFERENCES];

  logic [CW-1:0]         count_q;
  logic [COORD_BITS-1:0] qx_q, qy_q, qw_q, qh_q;
  logic [AW-1:0]         rd_q;
  logic [CW-1:0]         scan_q;

  // stage 1: memory read
  logic          v1_q;
  logic [AW-1:0] i1_q;
  logic [GW-1:0] g1_q;
  // stage 2: extents
  logic          v2_q, ov2_q;
  logic [AW-1:0] i2_q;
  logic [COORD_BITS-1:0] dx2_q, dy2_q, rw2_q, rh2_q;
  // stage 3: products
  logic          v3_q, ov3_q;
  logic [AW-1:0] i3_q;
  logic [IW-1:0] in3_q, ra3_q;
  // stage 4: sum
  logic          v4_q, ov4_q;
  logic [AW-1:0] i4_q;
  logic [IW-1:0] in4_q;
  logic [SW-1:0] sm4_q;
  // stage 5: threshold and best products
  logic          v5_q, ok5_q;
  logic [AW-1:0] i5_q;
  logic [IW-1:0] in5_q;
  logic [SW-1:0] sm5_q;
  logic [IW+SW-1:0] pa5_q, pb5_q;

  logic          best_v_q;
  logic [AW-1:0] best_i_q;
  logic [IW-1:0] best_in_q;
  logic [SW-1:0] best_sm_q;

  logic [NW-1:0]  num_q;
  logic [NW-1:0]  quo_q;
  logic [SW:0]    rem_q;
  logic [DCW-1:0] dcnt_q;

  logic [LW-1:0] lab_q;
  logic          status_q;

  logic [EW-1:0] qx1, qy1, rx1, ry1;
  logic [COORD_BITS-1:0] rx, ry, rw, rh;
  logic [EW-1:0] sx, sy, ex, ey;
  logic [SW:0]   rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.add && (count_q != CW'(MAX_REFERENCES))) begin
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add && (count_q != CW'(MAX_REFERENCES))) begin
      geo_mem[count_q[AW-1:0]] <= {in_item_i.box_x[COORD_BITS-1:0],
        in_item_i.box_y[COORD_BITS-1:0], in_item_i.box_width[COORD_BITS-1:0],
        in_item_i.box_height[COORD_BITS-1:0]};
      lab_mem[count_q[AW-1:0]] <= {in_item_i.label_class,
        in_item_i.label_confidence, in_item_i.label_color};
    end
    g1_q  <= geo_mem[rd_q];
    lab_q <= lab_mem[best_i_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      qx_q <= in_item_i.box_x[COORD_BITS-1:0];
      qy_q <= in_item_i.box_y[COORD_BITS-1:0];
      qw_q <= in_item_i.box_width[COORD_BITS-1:0];
      qh_q <= in_item_i.box_height[COORD_BITS-1:0];
      status_q <= (in_item_i.operation == OP_ADD) && (count_q == CW'(MAX_REFERENCES));
    end
  end

  // address walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      scan_q <= '0;
      v1_q   <= 1'b0;
    end else if (cmd_i.scan_start) begin
      rd_q   <= '0;
      scan_q <= '0;
      v1_q   <= 1'b0;
    end else if (cmd_i.scan_step) begin
      v1_q   <= (scan_q < count_q);
      i1_q   <= rd_q;
      scan_q <= scan_q + 1'b1;
      rd_q   <= rd_q + 1'b1;
    end else begin
      v1_q <= 1'b0;
    end
  end

  assign {rx, ry, rw, rh} = g1_q;
  assign qx1 = {1'b0, qx_q};
  assign qy1 = {1'b0, qy_q};
  assign rx1 = {1'b0, rx};
  assign ry1 = {1'b0, ry};
  assign sx = (qx1 > rx1) ? qx1 : rx1;
  assign sy = (qy1 > ry1) ? qy1 : ry1;
  always_comb begin
    ex = ((qx1 + EW'(qw_q)) < (rx1 + EW'(rw))) ? (qx1 + EW'(qw_q)) : (rx1 + EW'(rw));
    ey = ((qy1 + EW'(qh_q)) < (ry1 + EW'(rh))) ? (qy1 + EW'(qh_q)) : (ry1 + EW'(rh));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i2_q  <= i1_q;
    ov2_q <= (ex > sx) && (ey > sy);
    dx2_q <= COORD_BITS'(ex - sx);
    dy2_q <= COORD_BITS'(ey - sy);
    rw2_q <= rw;
    rh2_q <= rh;
    i3_q  <= i2_q;
    ov3_q <= ov2_q;
    in3_q <= dx2_q * dy2_q;
    ra3_q <= rw2_q * rh2_q;
    i4_q  <= i3_q;
    ov4_q <= ov3_q;
    in4_q <= in3_q;
    sm4_q <= SW'(ra3_q) + SW'(qw_q * qh_q);
    i5_q  <= i4_q;
    in5_q <= in4_q;
    sm5_q <= sm4_q;
    ok5_q <= ov4_q && (sm4_q != '0) &&
             (({in4_q, 17'd0}) > ((IW+17)'(min_rate_i) * (IW+17)'(sm4_q)));
    pa5_q <= in4_q * best_sm_q;
    pb5_q <= best_in_q * sm4_q;
  end

  // best products in stage 5 use the best as of stage 4; a newer best from
  // the previous entry is resolved by comparing against it directly
  logic better;
  logic [IW+SW-1:0] pa_fix, pb_fix;
  logic upd_prev;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) upd_prev <= 1'b0;
    else         upd_prev <= v5_q && ok5_q && better;
  end
  assign pa_fix = in5_q * best_sm_q;
  assign pb_fix = best_in_q * sm5_q;
  assign better = upd_prev ? (pa_fix > pb_fix) : (pa5_q > pb5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_v_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      best_v_q <= 1'b0;
    end else if (v5_q && ok5_q && better) begin
      best_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      best_i_q  <= '0;
      best_in_q <= '0;
      best_sm_q <= SW'(1);
    end else if (v5_q && ok5_q && better) begin
      best_i_q  <= i5_q;
      best_in_q <= in5_q;
      best_sm_q <= sm5_q;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_q[SW-1:0], num_q[NW-1]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DCW'(NW);
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= {best_in_q, 17'd0};
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      if (rem_sh >= {1'b0, best_sm_q}) begin
        rem_q <= rem_sh - {1'b0, best_sm_q};
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  logic query_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) query_q <= (in_item_i.operation == OP_QUERY);
  end

  assign sts_o.scan_last  = (scan_q >= count_q);
  assign sts_o.pipe_empty = !(v1_q || v2_q || v3_q || v4_q || v5_q);
  assign sts_o.div_done   = (dcnt_q == DCW'(1));
  assign sts_o.is_match   = best_v_q;

  logic hit;
  assign hit = query_q && best_v_q;
  always_comb begin
    out_item_o.status           = status_q;
    out_item_o.matched          = hit;
    out_item_o.match_index      = hit ? IDX_OUT_W'(best_i_q) : '0;
    out_item_o.match_class      = hit ? lab_q[47:40] : '0;
    out_item_o.match_confidence = hit ? lab_q[39:24] : '0;
    out_item_o.match_color      = hit ? lab_q[23:0] : '0;
    out_item_o.overlap_rate     = !hit ? '0 :
      ((quo_q > NW'(16'hFFFF)) ? 16'hFFFF : quo_q[15:0]);
    out_item_o.entry_count      = CNT_OUT_W'(count_q);
  end

endmodule

FILE: sv/bolm_checker.sv
// ----------------------------------------------------------------------------
// bolm_checker
// port level checks for the box overlap label matcher
// ----------------------------------------------------------------------------
module bolm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input bolm_pkg::out_item_t out_item_o,
  input logic                out_valid_o,
  input logic                out_ready_i
);
  import bolm_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed under stall");

  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.matched |->
      out_item_o.overlap_rate == '0 && out_item_o.match_index == '0)
    else $error("match fields set without a match");

  a_status_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status |-> !out_item_o.matched)
    else $error("dropped add reports a match");

endmodule

bind box_overlap_label_matcher bolm_checker u_bolm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_item_o  (out_item_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);
